// ===== rtl/rycavg_pkg.sv =====
// ----------------------------------------------------------------------------
// rycavg_pkg: shared types and constants for the RGB to YCbCr converter
// Q8 BT.601 coefficients, register defaults and the per-pixel result type.
// ----------------------------------------------------------------------------
package rycavg_pkg;

  // Field widths fixed by the pixel and register formats.
  localparam int unsigned PixW  = 8;
  localparam int unsigned RowWW = 13;
  localparam int unsigned Q8W   = 16;
  localparam int unsigned SumW  = 18;
  localparam int unsigned ArithW = 20;

  // Register and parameter defaults.
  localparam logic [RowWW-1:0] DefRowWidth = 13'd640;
  localparam int unsigned      DefMaxWidth = 4096;

  // Q8 coefficients (value x 256, rounded to nearest).
  localparam logic signed [9:0] YR  = 10'sd66;
  localparam logic signed [9:0] YG  = 10'sd129;
  localparam logic signed [9:0] YB  = 10'sd25;
  localparam logic signed [9:0] CbR = -10'sd38;
  localparam logic signed [9:0] CbG = -10'sd74;
  localparam logic signed [9:0] CbB = 10'sd112;
  localparam logic signed [9:0] CrR = 10'sd112;
  localparam logic signed [9:0] CrG = -10'sd94;
  localparam logic signed [9:0] CrB = -10'sd18;

  localparam logic signed [ArithW-1:0] YOff  = 20'sd4096;   // 16 * 256
  localparam logic signed [ArithW-1:0] COff  = 20'sd32768;  // 128 * 256
  localparam logic signed [ArithW-1:0] Q8Max = 20'sd65280;  // 255 * 256

  // Clamped Q8 components of one pixel.
  typedef struct packed {
    logic [Q8W-1:0] yq;
    logic [Q8W-1:0] cbq;
    logic [Q8W-1:0] crq;
  } csc_t;

  function automatic logic [Q8W-1:0] clamp_q8(input logic signed [ArithW-1:0] v);
    logic [Q8W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > Q8Max) begin
      res = Q8Max[Q8W-1:0];
    end else begin
      res = v[Q8W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/rycavg_csc.sv =====
// ----------------------------------------------------------------------------
// rycavg_csc: per-pixel colour space conversion
// Computes clamped Q8 Y, Cb and Cr for one RGB pixel with constant multiplies.
// ----------------------------------------------------------------------------
module rycavg_csc (
  input  logic [rycavg_pkg::PixW-1:0] red_i,
  input  logic [rycavg_pkg::PixW-1:0] green_i,
  input  logic [rycavg_pkg::PixW-1:0] blue_i,
  output rycavg_pkg::csc_t            csc_o
);

  logic signed [9:0] r_s, g_s, b_s;
  logic signed [rycavg_pkg::ArithW-1:0] y_raw, cb_raw, cr_raw;

  assign r_s = $signed({2'b00, red_i});
  assign g_s = $signed({2'b00, green_i});
  assign b_s = $signed({2'b00, blue_i});

  always_comb begin
    y_raw  = r_s * rycavg_pkg::YR  + g_s * rycavg_pkg::YG  + b_s * rycavg_pkg::YB
           + rycavg_pkg::YOff;
    cb_raw = r_s * rycavg_pkg::CbR + g_s * rycavg_pkg::CbG + b_s * rycavg_pkg::CbB
           + rycavg_pkg::COff;
    cr_raw = r_s * rycavg_pkg::CrR + g_s * rycavg_pkg::CrG + b_s * rycavg_pkg::CrB
           + rycavg_pkg::COff;
  end

  assign csc_o.yq  = rycavg_pkg::clamp_q8(y_raw);
  assign csc_o.cbq = rycavg_pkg::clamp_q8(cb_raw);
  assign csc_o.crq = rycavg_pkg::clamp_q8(cr_raw);

endmodule

// ===== rtl/rgb_to_yuv_chroma_avg_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_yuv_chroma_avg_unit: RGB to YCbCr with 4:1 chroma averaging
// Gives the luma of every pixel and, on the last pixel of each aligned group
// of four within a row, the floor of the mean Cb and Cr over that group.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid_i/in_stall_o  red, green, blue, last_of_frame
//  out      source     out_valid_o/out_stall_i luma, cb_avg, cr_avg,
//                                              chroma_valid, frame_end
//  cfg      sink       cfg_valid_i/cfg_ready_o row width (13 bits)
//
//  One pixel is accepted per cycle while the output is not stalled; each result
//  passes through the input register and then the result register. The group
//  accumulator is updated as each pixel moves on to the result register.
//  A stall on the output holds the result register and, once the input
//  register is also full, stalls the input. Reset clears the column count,
//  the group sums and the row width to 640 pixels.
// ----------------------------------------------------------------------------
module rgb_to_yuv_chroma_avg_unit #(
  parameter int unsigned MAX_WIDTH = rycavg_pkg::DefMaxWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // pixel input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rycavg_pkg::PixW-1:0]  red_i,
  input  logic [rycavg_pkg::PixW-1:0]  green_i,
  input  logic [rycavg_pkg::PixW-1:0]  blue_i,
  input  logic                         last_of_frame_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rycavg_pkg::PixW-1:0]  luma_o,
  output logic [rycavg_pkg::PixW-1:0]  cb_avg_o,
  output logic [rycavg_pkg::PixW-1:0]  cr_avg_o,
  output logic                         chroma_valid_o,
  output logic                         frame_end_o,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rycavg_pkg::RowWW-1:0] cfg_row_width_i
);

  localparam int unsigned CntW = $clog2(MAX_WIDTH);
  localparam int unsigned MaxBits = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CmpW = (MaxBits > rycavg_pkg::RowWW) ? MaxBits : rycavg_pkg::RowWW;
  localparam logic [CmpW-1:0] MaxWidthC = CmpW'(MAX_WIDTH);
  localparam int unsigned SumW = rycavg_pkg::SumW;
  localparam int unsigned Q8W = rycavg_pkg::Q8W;
  localparam int unsigned PixW = rycavg_pkg::PixW;

  // Configuration register
  logic [rycavg_pkg::RowWW-1:0] row_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= rycavg_pkg::DefRowWidth;
    end else if (cfg_valid_i && cfg_ready_o) begin
      row_width_q <= cfg_row_width_i;
    end
  end

  // Input register
  logic            s1_valid_q;
  logic [PixW-1:0] s1_red_q, s1_green_q, s1_blue_q;
  logic            s1_last_q;
  logic            s1_adv, in_take;

  assign s1_adv     = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_red_q   <= red_i;
      s1_green_q <= green_i;
      s1_blue_q  <= blue_i;
      s1_last_q  <= last_of_frame_i;
    end
  end

  // Conversion
  rycavg_pkg::csc_t csc;

  rycavg_csc u_csc (
    .red_i   (s1_red_q),
    .green_i (s1_green_q),
    .blue_i  (s1_blue_q),
    .csc_o   (csc)
  );

  // Group accumulation and column tracking
  logic [CntW-1:0] col_q, col_d;
  logic [SumW-1:0] cb_sum_q, cb_sum_d, cr_sum_q, cr_sum_d;
  logic [SumW-1:0] cb_acc, cr_acc;
  logic [CmpW-1:0] row_w_ext, eff_width, col_next;
  logic            grp_start, grp_end, row_done;

  assign grp_start = (col_q[1:0] == 2'd0);
  assign grp_end   = (col_q[1:0] == 2'd3);

  assign cb_acc = grp_start ? SumW'(csc.cbq) : cb_sum_q + SumW'(csc.cbq);
  assign cr_acc = grp_start ? SumW'(csc.crq) : cr_sum_q + SumW'(csc.crq);

  // A zero or oversized width behaves as the largest supported width.
  assign row_w_ext = CmpW'(row_width_q);
  assign eff_width = (row_width_q == '0 || row_w_ext > MaxWidthC) ? MaxWidthC : row_w_ext;
  assign col_next  = CmpW'(col_q) + CmpW'(1);
  assign row_done  = s1_last_q || (col_next >= eff_width);

  always_comb begin
    if (row_done) begin
      col_d    = '0;
      cb_sum_d = '0;
      cr_sum_d = '0;
    end else begin
      col_d    = col_next[CntW-1:0];
      cb_sum_d = cb_acc;
      cr_sum_d = cr_acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      cb_sum_q <= '0;
      cr_sum_q <= '0;
    end else if (s1_adv) begin
      col_q    <= col_d;
      cb_sum_q <= cb_sum_d;
      cr_sum_q <= cr_sum_d;
    end
  end

  // Result register
  logic            out_valid_q;
  logic [PixW-1:0] luma_q, cb_avg_q, cr_avg_q;
  logic            chroma_valid_q, frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The integer mean of four Q8 values is their sum shifted down by ten.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      luma_q         <= csc.yq[Q8W-1:Q8W-PixW];
      cb_avg_q       <= grp_end ? cb_acc[SumW-1:SumW-PixW] : '0;
      cr_avg_q       <= grp_end ? cr_acc[SumW-1:SumW-PixW] : '0;
      chroma_valid_q <= grp_end;
      frame_end_q    <= s1_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign luma_o         = luma_q;
  assign cb_avg_o       = cb_avg_q;
  assign cr_avg_o       = cr_avg_q;
  assign chroma_valid_o = chroma_valid_q;
  assign frame_end_o    = frame_end_q;

endmodule

// ===== rtl/rycavg_chk.sv =====
// ----------------------------------------------------------------------------
// rycavg_chk: port-level checks for the chroma averaging converter
// Watches the top-level ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module rycavg_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rycavg_pkg::PixW-1:0] luma_o,
  input logic [rycavg_pkg::PixW-1:0] cb_avg_o,
  input logic [rycavg_pkg::PixW-1:0] cr_avg_o,
  input logic                        chroma_valid_o,
  input logic                        frame_end_o
);

  logic out_take;
  logic last_chroma_q;

  assign out_take = out_valid_o && !out_stall_i;

  // Remembers whether the previous delivered result carried chroma.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_chroma_q <= 1'b0;
    end else if (out_take) begin
      last_chroma_q <= chroma_valid_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(luma_o) && $stable(cb_avg_o)
      && $stable(cr_avg_o) && $stable(chroma_valid_o) && $stable(frame_end_o))
    else $error("stalled result changed or vanished");

  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chroma_valid_o |-> cb_avg_o == '0 && cr_avg_o == '0)
    else $error("chroma fields non-zero without chroma_valid");

  a_no_adjacent_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && chroma_valid_o |-> !last_chroma_q)
    else $error("two consecutive results carry chroma");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while result register is empty");

endmodule

bind rgb_to_yuv_chroma_avg_unit rycavg_chk u_rycavg_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .luma_o         (luma_o),
  .cb_avg_o       (cb_avg_o),
  .cr_avg_o       (cr_avg_o),
  .chroma_valid_o (chroma_valid_o),
  .frame_end_o    (frame_end_o)
);

// ===== sim/tb_rgb_to_yuv_chroma_avg_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_to_yuv_chroma_avg_unit: regression bench for the RGB to YCbCr unit
// Walks a short table of pixels and then random pixel bursts under a series
// of row widths. Results of typed table rows are compared with hand-written
// values, the rest with a local BT.601 Q8 converter; both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_rgb_to_yuv_chroma_avg_unit;

  localparam int unsigned PixW     = rycavg_pkg::PixW;
  localparam int unsigned RowWW    = rycavg_pkg::RowWW;
  localparam int          MaxWidth = rycavg_pkg::DefMaxWidth;
  localparam int          Q8Top    = 255 * 256;
  localparam int          CycleLimit = 400000;
  localparam int          NumPhases  = 16;
  localparam int          PhaseItems = 80;
  localparam int          NumRows    = 20;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic            last;
  } pixel_t;

  typedef struct packed {
    logic [PixW-1:0] luma;
    logic [PixW-1:0] cb_avg;
    logic [PixW-1:0] cr_avg;
    logic            chroma_valid;
    logic            frame_end;
  } result_t;

  // One row of the directed table; typed rows carry a hand-written result.
  typedef struct packed {
    pixel_t  px;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [PixW-1:0]  red_i;
  logic [PixW-1:0]  green_i;
  logic [PixW-1:0]  blue_i;
  logic             last_of_frame_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [PixW-1:0]  luma_o;
  logic [PixW-1:0]  cb_avg_o;
  logic [PixW-1:0]  cr_avg_o;
  logic             chroma_valid_o;
  logic             frame_end_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [RowWW-1:0] cfg_row_width_i;

  rgb_to_yuv_chroma_avg_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .last_of_frame_i (last_of_frame_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .luma_o          (luma_o),
    .cb_avg_o        (cb_avg_o),
    .cr_avg_o        (cr_avg_o),
    .chroma_valid_o  (chroma_valid_o),
    .frame_end_o     (frame_end_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_row_width_i (cfg_row_width_i)
  );

  // Converter state mirrored from the block.
  int               conv_row_width;
  int               conv_column;
  logic [17:0]      conv_cb_sum;
  logic [17:0]      conv_cr_sum;

  result_t          expected_pixels[$];
  int               error_count;
  int               cycle_count;
  bit               quiet;
  dir_row_t         directed_rows [NumRows];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int saturate_q8(input int v);
    int res;
    if (v < 0) begin
      res = 0;
    end else if (v > Q8Top) begin
      res = Q8Top;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Converts one accepted pixel and advances the row and group state.
  function automatic result_t convert_pixel(input pixel_t px);
    int      r, g, b, yq, cbq, crq, width, col;
    result_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    col = conv_column;
    yq  = saturate_q8(66 * r + 129 * g + 25 * b + 16 * 256);
    cbq = saturate_q8(-38 * r - 74 * g + 112 * b + 128 * 256);
    crq = saturate_q8(112 * r - 94 * g - 18 * b + 128 * 256);
    if (conv_row_width == 0 || conv_row_width > MaxWidth) begin
      width = MaxWidth;
    end else begin
      width = conv_row_width;
    end
    if (col % 4 == 0) begin
      conv_cb_sum = 18'(cbq);
      conv_cr_sum = 18'(crq);
    end else begin
      conv_cb_sum = conv_cb_sum + 18'(cbq);
      conv_cr_sum = conv_cr_sum + 18'(crq);
    end
    res = '0;
    res.luma = 8'(yq >> 8);
    if (col % 4 == 3) begin
      res.cb_avg       = conv_cb_sum[17:10];
      res.cr_avg       = conv_cr_sum[17:10];
      res.chroma_valid = 1'b1;
    end
    res.frame_end = px.last;
    if (px.last || col + 1 >= width) begin
      conv_column = 0;
      conv_cb_sum = '0;
      conv_cr_sum = '0;
    end else begin
      conv_column = col + 1;
    end
    return res;
  endfunction

  function automatic logic [PixW-1:0] random_component();
    logic [PixW-1:0] c;
    case ($urandom_range(0, 9))
      0: c = '0;
      1: c = '1;
      default: c = PixW'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red   = random_component();
    px.green = random_component();
    px.blue  = random_component();
    px.last  = ($urandom_range(0, 39) == 0);
    return px;
  endfunction

  // Presents one pixel request and records its expected result once accepted.
  task automatic send_pixel(input pixel_t px, input bit typed, input result_t typed_res);
    result_t res;
    while (!quiet && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    red_i           <= px.red;
    green_i         <= px.green;
    blue_i          <= px.blue;
    last_of_frame_i <= px.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = convert_pixel(px);
    if (typed) begin
      expected_pixels.push_back(typed_res);
    end else begin
      expected_pixels.push_back(res);
    end
  endtask

  // Drops the input request and waits until every result is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_row_width(input logic [RowWW-1:0] w);
    cfg_valid_i     <= 1'b1;
    cfg_row_width_i <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    conv_row_width = int'(w);
  endtask

  function automatic void compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 21);
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual luma %0d", $time, luma_o);
        error_count++;
      end else begin
        exp_r = expected_pixels.pop_front();
        compare_field("luma", int'(exp_r.luma), int'(luma_o));
        compare_field("cb_avg", int'(exp_r.cb_avg), int'(cb_avg_o));
        compare_field("cr_avg", int'(exp_r.cr_avg), int'(cr_avg_o));
        compare_field("chroma_valid", int'(exp_r.chroma_valid), int'(chroma_valid_o));
        compare_field("frame_end", int'(exp_r.frame_end), int'(frame_end_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("rgb_to_yuv_chroma_avg_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int               w;
    logic [RowWW-1:0] fixed_widths [12];
    result_t          none;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    red_i           = '0;
    green_i         = '0;
    blue_i          = '0;
    last_of_frame_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_row_width_i = '0;
    error_count     = 0;
    cycle_count     = 0;
    quiet           = 1'b0;
    conv_row_width  = int'(rycavg_pkg::DefRowWidth);
    conv_column     = 0;
    conv_cb_sum     = '0;
    conv_cr_sum     = '0;
    none            = '0;

    // Reset width of 640: the first rows sit at the start of one long row.
    directed_rows = '{
      '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd16,  8'd0,   8'd0,   1'b0, 1'b0}},
      '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, '{8'd235, 8'd0,   8'd0,   1'b0, 1'b0}},
      '{'{8'd255, 8'd0,   8'd0,   1'b0}, 1'b1, '{8'd81,  8'd0,   8'd0,   1'b0, 1'b0}},
      '{'{8'd0,   8'd0,   8'd255, 1'b0}, 1'b1, '{8'd40,  8'd146, 8'd151, 1'b1, 1'b0}},
      '{'{8'd0,   8'd255, 8'd0,   1'b1}, 1'b1, '{8'd144, 8'd0,   8'd0,   1'b0, 1'b1}},
      '{'{8'd255, 8'd255, 8'd0,   1'b0}, 1'b0, '0},
      '{'{8'd0,   8'd255, 8'd255, 1'b0}, 1'b0, '0},
      // A frame end inside a group drops the partial sums.
      '{'{8'd255, 8'd0,   8'd255, 1'b1}, 1'b0, '0},
      '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b0, '0},
      '{'{8'd1,   8'd2,   8'd4,   1'b0}, 1'b0, '0},
      '{'{8'hAA,  8'h55,  8'hAA,  1'b0}, 1'b0, '0},
      '{'{8'h55,  8'hAA,  8'h55,  1'b0}, 1'b0, '0},
      '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, '{8'd235, 8'd0,   8'd0,   1'b0, 1'b0}},
      '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, '{8'd235, 8'd0,   8'd0,   1'b0, 1'b0}},
      '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, '{8'd235, 8'd0,   8'd0,   1'b0, 1'b0}},
      '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, '{8'd235, 8'd128, 8'd128, 1'b1, 1'b0}},
      '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd16,  8'd0,   8'd0,   1'b0, 1'b0}},
      '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd16,  8'd0,   8'd0,   1'b0, 1'b0}},
      '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd16,  8'd0,   8'd0,   1'b0, 1'b0}},
      '{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, '{8'd16,  8'd128, 8'd128, 1'b1, 1'b1}}
    };

    // Widths 1 to 3 never complete a group; 0 and anything above the
    // maximum behave as the maximum width.
    fixed_widths = '{13'd4, 13'd7, 13'd1, 13'd4096, 13'd5, 13'd0,
                     13'd2, 13'd8191, 13'd6, 13'd3, 13'd12, 13'd4097};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].res);
    end
    drain();

    // The column count carries over between phases, so a width change
    // can also land part way through a row.
    for (int p = 0; p < NumPhases; p++) begin
      if (p < 12) begin
        w = int'(fixed_widths[p]);
      end else if ($urandom_range(0, 4) == 0) begin
        w = $urandom_range(0, 8191);
      end else begin
        w = $urandom_range(4, 40);
      end
      write_row_width(RowWW'(w));
      quiet = (p == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 5 && n == PhaseItems / 2) begin
          in_valid_i <= 1'b0;
          while (expected_pixels.size() != 0) @(posedge clk_i);
        end
        send_pixel(random_pixel(), 1'b0, none);
      end
      drain();
      quiet = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("rgb_to_yuv_chroma_avg_unit regression: pass");
    end else begin
      $display("rgb_to_yuv_chroma_avg_unit regression: fail");
    end
    $finish;
  end

endmodule
